// ----- hw/rtl/vdlf_pkg.sv -----
// vdlf_pkg: shared constants and the sequencer state type of the delay line.
// No dependencies; imported by variable_delay_line_with_feedback_core.
`timescale 1ns / 1ps

package vdlf_pkg;

    localparam int DEPTH_DEF          = 4096;
    localparam int SAMPLE_BITS_DEF    = 24;
    localparam int GAIN_FRAC_BITS_DEF = 16;

    // Control field widths are fixed by the interface.
    localparam int CTRL_BITS = 12;
    localparam logic [CTRL_BITS-1:0] MAX_DELAY_RST = {CTRL_BITS{1'b1}};

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_ADDR  = 5'b00100,
        S_MUL   = 5'b01000,
        S_SUM   = 5'b10000
    } state_t;

endpackage

// ----- hw/rtl/vdlf_ram.sv -----
// vdlf_ram: sample ring storage, one write port and one registered read port.
// Read-first on a same-address collision. No package dependencies.
`timescale 1ns / 1ps

module vdlf_ram #(
    parameter int DEPTH = 4096,
    parameter int WIDTH = 24,
    parameter int AW    = 12
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- hw/rtl/variable_delay_line_with_feedback_core.sv -----
// Variable delay line with feedback, top level.
// Depends on vdlf_pkg and vdlf_ram.
`timescale 1ns / 1ps

// Each input word carries one signed sample, a delay, a Q2.F feedback gain and
// a feedback offset. The sample is written at the ring head; the tail lies
// min(delay, max_delay, DEPTH-1) words behind the head and is read back; the
// tail times gain (rounded to nearest, ties up) is added with saturation into
// the entry min(feedback_delay, clamped delay) words after the tail; the tail
// value as it stands after that update is the result, and the head advances.
// Each word passes through accept, head write + tail read, multiply +
// feedback read and accumulate + write back, which stalls while the output
// slot is full; m_valid rises as it completes. The pace is set by the single
// ring memory with one write and one read port. A new word is taken while
// the previous result waits on m_ready. After reset a sweep zeroes the ring,
// one entry per cycle; s_ready stays low during it, max_delay writes are taken.

module variable_delay_line_with_feedback_core
    import vdlf_pkg::*;
#(
    parameter int DEPTH          = DEPTH_DEF,
    parameter int SAMPLE_BITS    = SAMPLE_BITS_DEF,
    parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,

    input  logic                               cfg_wr_en,
    input  logic [CTRL_BITS-1:0]               cfg_wr_data,

    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic signed [SAMPLE_BITS-1:0]      s_sample,
    input  logic [CTRL_BITS-1:0]               s_delay_samples,
    input  logic signed [GAIN_FRAC_BITS+1:0]   s_feedback_gain,
    input  logic [CTRL_BITS-1:0]               s_feedback_delay,

    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [SAMPLE_BITS-1:0]      m_out_sample
);

    localparam int GAIN_BITS = GAIN_FRAC_BITS + 2;
    localparam int AW        = $clog2(DEPTH);
    localparam int EW        = (AW > CTRL_BITS) ? AW : CTRL_BITS;  // clamp compare width
    localparam int PW        = SAMPLE_BITS + GAIN_BITS;           // product width
    localparam int QW        = PW + 1 - GAIN_FRAC_BITS;           // scaled product width
    localparam int SUMW      = QW + 1;

    localparam logic [EW-1:0]       LIMIT_E  = EW'(DEPTH - 1);
    localparam logic [AW-1:0]       LAST_A   = AW'(DEPTH - 1);
    localparam logic [AW:0]         DEPTH_X  = (AW+1)'(DEPTH);
    localparam logic signed [PW:0]  RND_HALF = (PW+1)'(1) <<< (GAIN_FRAC_BITS - 1);

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    state_t                        state_reg, state_next;
    logic [AW-1:0]                 clr_cnt_reg, clr_cnt_next;
    logic [AW-1:0]                 head_reg, head_next;
    logic [CTRL_BITS-1:0]          max_delay_reg;

    // per-word working set
    logic signed [SAMPLE_BITS-1:0] x_reg;
    logic signed [GAIN_BITS-1:0]   gain_reg;
    logic [AW-1:0]                 shift_reg;
    logic [AW-1:0]                 fd_reg;
    logic [AW-1:0]                 tail_reg;
    logic                          tail_fwd_reg;   // zero delay: tail is head
    logic                          fd_zero_reg;    // feedback lands on the tail
    logic signed [SAMPLE_BITS-1:0] t_reg;
    logic signed [PW-1:0]          prod_reg;

    logic                          m_valid_reg;
    logic signed [SAMPLE_BITS-1:0] m_out_sample_reg;

    // ------------------------------------------------------------------
    // Combinational
    // ------------------------------------------------------------------
    logic                          accept;
    logic                          out_free;
    logic [EW-1:0]                 dly_e, max_e, fd_e, sh1_e, sh_e, fdc_e;
    logic [AW:0]                   tail_x, feed_x;
    logic [AW-1:0]                 tail_c, feed_c;
    logic signed [SAMPLE_BITS-1:0] t_c;
    logic signed [PW:0]            rnd;
    logic signed [QW-1:0]          q;
    logic signed [SUMW-1:0]        sum;
    logic signed [SAMPLE_BITS-1:0] sat;
    logic                          sum_ovf;

    logic                          ram_we;
    logic [AW-1:0]                 ram_waddr;
    logic [SAMPLE_BITS-1:0]        ram_wdata;
    logic [AW-1:0]                 ram_raddr;
    logic [SAMPLE_BITS-1:0]        ram_rdata;

    assign s_ready  = (state_reg == S_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    // delay and offset clamps
    always_comb begin
        dly_e = EW'(s_delay_samples);
        max_e = EW'(max_delay_reg);
        fd_e  = EW'(s_feedback_delay);
        sh1_e = (dly_e > max_e) ? max_e : dly_e;
        sh_e  = (sh1_e > LIMIT_E) ? LIMIT_E : sh1_e;
        fdc_e = (fd_e > sh_e) ? sh_e : fd_e;
    end

    // ring positions
    always_comb begin
        if (head_reg >= shift_reg) begin
            tail_x = {1'b0, head_reg} - {1'b0, shift_reg};
        end else begin
            tail_x = {1'b0, head_reg} + DEPTH_X - {1'b0, shift_reg};
        end
        tail_c = tail_x[AW-1:0];
        feed_x = {1'b0, tail_reg} + {1'b0, fd_reg};
        if (feed_x >= DEPTH_X) begin
            feed_x = feed_x - DEPTH_X;
        end
        feed_c = feed_x[AW-1:0];
    end

    // tail value: read-first RAM misses the same-cycle head write
    assign t_c = tail_fwd_reg ? x_reg : $signed(ram_rdata);

    // round, accumulate, saturate
    always_comb begin
        rnd     = (PW+1)'(prod_reg) + RND_HALF;
        q       = rnd[PW:GAIN_FRAC_BITS];
        sum     = SUMW'($signed(ram_rdata)) + SUMW'(q);
        sum_ovf = (sum[SUMW-1:SAMPLE_BITS-1] != {(SUMW-SAMPLE_BITS+1){1'b0}}) &&
                  (sum[SUMW-1:SAMPLE_BITS-1] != {(SUMW-SAMPLE_BITS+1){1'b1}});
        if (sum_ovf) begin
            sat = sum[SUMW-1] ? {1'b1, {(SAMPLE_BITS-1){1'b0}}}
                              : {1'b0, {(SAMPLE_BITS-1){1'b1}}};
        end else begin
            sat = sum[SAMPLE_BITS-1:0];
        end
    end

    // memory port steering
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = head_reg;
        ram_wdata = x_reg;
        ram_raddr = feed_c;
        case (state_reg)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = clr_cnt_reg;
                ram_wdata = '0;
            end
            S_ADDR: begin
                ram_we    = 1'b1;
                ram_raddr = tail_c;
            end
            S_SUM: begin
                ram_we    = out_free;
                ram_waddr = feed_c;
                ram_wdata = sat;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    // sequencer
    always_comb begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        head_next    = head_reg;
        case (state_reg)
            S_CLEAR: begin
                clr_cnt_next = clr_cnt_reg + AW'(1);
                if (clr_cnt_reg == LAST_A) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    state_next = S_ADDR;
                end
            end
            S_ADDR: begin
                state_next = S_MUL;
            end
            S_MUL: begin
                state_next = S_SUM;
            end
            S_SUM: begin
                if (out_free) begin
                    state_next = S_IDLE;
                    head_next  = (head_reg == LAST_A) ? '0 : head_reg + AW'(1);
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            head_reg      <= '0;
            max_delay_reg <= MAX_DELAY_RST;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            head_reg    <= head_next;
            if (cfg_wr_en) begin
                max_delay_reg <= cfg_wr_data;
            end
            if (state_reg == S_SUM && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge aclk) begin
        if (accept) begin
            x_reg       <= s_sample;
            gain_reg    <= s_feedback_gain;
            shift_reg   <= AW'(sh_e);
            fd_reg      <= AW'(fdc_e);
            tail_fwd_reg <= (sh_e == '0);
            fd_zero_reg <= (fdc_e == '0);
        end
        if (state_reg == S_ADDR) begin
            tail_reg <= tail_c;
        end
        if (state_reg == S_MUL) begin
            t_reg    <= t_c;
            prod_reg <= PW'(t_c) * PW'(gain_reg);
        end
        if (state_reg == S_SUM && out_free) begin
            m_out_sample_reg <= fd_zero_reg ? sat : t_reg;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_out_sample = m_out_sample_reg;

    vdlf_ram #(
        .DEPTH (DEPTH),
        .WIDTH (SAMPLE_BITS),
        .AW    (AW)
    ) u_ring (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

`ifndef SYNTHESIS
    a_clear_after_reset: assert property (@(posedge aclk)
        !aresetn |=> (state_reg == S_CLEAR) && (clr_cnt_reg == '0))
        else $error("ring clear sweep not restarted by reset");

    a_clamped_offsets: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_ADDR) |-> (fd_reg <= shift_reg) && (shift_reg <= LAST_A))
        else $error("feedback offset or delay outside clamp");

    a_result_from_sum: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> ($past(state_reg) == S_SUM))
        else $error("result raised outside accumulate step");

    a_stall_holds_sum: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SUM && m_valid_reg && !m_ready) |=> (state_reg == S_SUM))
        else $error("write-back left while output slot busy");

    a_head_advances: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SUM && out_free) |=> (head_reg != $past(head_reg)))
        else $error("head did not advance on completion");
`endif

endmodule
